>>> design/crypto_chip_command_framer_assert.svh
// Assertion macros shared by the framer checkers.
`ifndef CRYPTO_CHIP_COMMAND_FRAMER_ASSERT_SVH
`define CRYPTO_CHIP_COMMAND_FRAMER_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define CCF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("framer assertion failed");

// Clocked assertion that also holds across reset.
`define CCF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("framer assertion failed");

`endif

>>> design/ccf_pkg.sv
package ccf_pkg;

  // Input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERD_OK        = 3'd0;
  localparam logic [2:0] VERD_BAD_COUNT = 3'd1;
  localparam logic [2:0] VERD_CRC       = 3'd2;
  localparam logic [2:0] VERD_DEVICE    = 3'd3;
  localparam logic [2:0] VERD_LENGTH    = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_ADDR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUCCESS   = 1'd1;

  localparam logic [7:0]  WORD_ADDR_RESET = 8'd3;
  localparam logic [7:0]  SUCCESS_RESET   = 8'd0;
  localparam logic [15:0] CRC_POLY        = 16'h8005;
  localparam logic [7:0]  PKT_OVERHEAD    = 8'd7;
  localparam logic [7:0]  SHORT_REPLY     = 8'd4;
  localparam logic [7:0]  REPLY_OVERHEAD  = 8'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_TXD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_REPLY,
    ST_CHK_START,
    ST_CHK_RD,
    ST_CHK_ACC,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_PAY_RD,
    ST_PAY_OUT,
    ST_VERDICT
  } state_t;

  // Control of the shared CRC unit
  typedef struct packed {
    logic       clr;
    logic       step;
    logic [7:0] din;
  } crc_ctl_t;

endpackage

>>> design/ccf_if.sv
// Command / reply byte channel into the framer
interface ccf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  opcode;
  logic [7:0]  param_one;
  logic [15:0] param_two;
  logic [5:0]  data_count;
  logic [5:0]  reply_payload_len;
  logic [7:0]  data_byte;

  modport source (output valid, command, opcode, param_one, param_two, data_count,
                  reply_payload_len, data_byte, input ready);
  modport sink (input valid, command, opcode, param_one, param_two, data_count,
                reply_payload_len, data_byte, output ready);
endinterface

// Result channel out of the framer
interface ccf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] verdict;
  logic [7:0] device_status;
  logic       last;

  modport source (output valid, kind, out_byte, verdict, device_status, last,
                  input ready);
  modport sink (input valid, kind, out_byte, verdict, device_status, last,
                output ready);
endinterface

>>> design/ccf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module ccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ccf_crc.sv
// Shared CRC-16 (poly 0x8005, init 0, LSB-first) byte step unit
module ccf_crc (
  input  logic            clk,
  input  ccf_pkg::crc_ctl_t ctl,
  output logic [15:0]     crc
);

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (b[k] != r[15]) begin
        r = {r[14:0], 1'b0} ^ ccf_pkg::CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      crc <= '0;
    end else if (ctl.step) begin
      crc <= crc_byte(crc, ctl.din);
    end
  end

endmodule

>>> design/crypto_chip_command_framer.sv
// Command framer and reply checker for a secure element.
// req carries start items (opcode, params, data length, expected reply length),
// command data bytes and reply bytes; res carries transmit bytes, reply payload
// bytes and one verdict per reply. A transaction moves on valid & ready.
// A start emits word address, count, opcode, param_one, param_two (low first),
// then the data bytes as they arrive, then the CRC low/high (last set).
// The block takes no item while a header, data byte or CRC byte is being emitted.
// Reply bytes are taken one per cycle; the final one starts the check. The check
// walks the reply store through one shared CRC unit, reading and then accumulating
// each byte, then compares the two CRC bytes, then emits the payload bytes.
// The reply store is a RAM; a fill count makes unwritten entries read as zero,
// so no clearing pass is needed after reset.
// Reset empties the result register and returns to idle; configuration returns
// to word address 3 and success code 0. When res stalls, the result holds and
// the sequencer waits for the slot to empty.
module crypto_chip_command_framer #(
  parameter int PACKET_BYTES = 40,
  parameter int MAX_DATA     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ccf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  ccf_in_if.sink                          req,
  ccf_out_if.source                       res
);

  localparam int AW   = $clog2(PACKET_BYTES);
  localparam int RW   = $clog2(PACKET_BYTES + 1);
  localparam int DMAX = (MAX_DATA < PACKET_BYTES - 8) ? MAX_DATA : PACKET_BYTES - 8;
  localparam int RMAX = PACKET_BYTES - 3;
  localparam logic [7:0] PKT_MAX = 8'(PACKET_BYTES);

  ccf_pkg::state_t state, state_next;

  logic [7:0]  word_addr, success;
  logic [2:0]  hdr_idx, hdr_idx_next;
  logic [7:0]  count_r, opcode_r, p1_r, byte_r;
  logic [15:0] p2_r;
  logic [5:0]  data_left, data_left_next;
  logic [5:0]  exp_payload;
  logic [RW-1:0] received, received_next;
  logic [7:0]  cnt_r, status_r;
  logic [AW-1:0] idx, idx_next;
  logic        cmp_hi, cmp_hi_next;
  logic [5:0]  pay_left, pay_left_next;
  logic [2:0]  verd_r, verd_next;
  logic        rd_ok;

  ccf_pkg::crc_ctl_t crc_ctl;
  logic [15:0] crc;
  logic [7:0]  rdata, rd_byte;

  logic slot_free, load;
  logic [1:0] load_kind;
  logic [7:0] load_byte, load_status;
  logic [2:0] load_verdict;
  logic       load_last;

  logic acc;
  logic ram_we;
  logic [5:0] dlen_sat, rlen_sat;
  logic [7:0] want;
  logic [7:0] payload_len;

  assign acc       = req.valid & req.ready;
  assign slot_free = !res.valid | res.ready;
  assign req.ready = (state == ccf_pkg::ST_IDLE) || (state == ccf_pkg::ST_DATA) ||
                     (state == ccf_pkg::ST_REPLY);

  assign dlen_sat = (req.data_count > 6'(DMAX)) ? 6'(DMAX) : req.data_count;
  assign rlen_sat = (req.reply_payload_len > 6'(RMAX)) ? 6'(RMAX) : req.reply_payload_len;
  assign want     = (exp_payload == '0) ? ccf_pkg::SHORT_REPLY
                                        : 8'(exp_payload) + ccf_pkg::REPLY_OVERHEAD;
  assign payload_len = (cnt_r == ccf_pkg::SHORT_REPLY) ? 8'd0
                                                       : cnt_r - ccf_pkg::REPLY_OVERHEAD;
  assign ram_we = acc && (req.command == ccf_pkg::CMD_REPLY) &&
                  (state == ccf_pkg::ST_REPLY);

  // Entries past the fill count read as cleared
  assign rd_byte = rd_ok ? rdata : 8'd0;

  ccf_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (received[AW-1:0]),
    .wdata (req.data_byte),
    .raddr (idx),
    .rdata (rdata)
  );

  ccf_crc u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_addr <= ccf_pkg::WORD_ADDR_RESET;
      success   <= ccf_pkg::SUCCESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccf_pkg::CFG_WORD_ADDR: word_addr <= cfg_data;
        ccf_pkg::CFG_SUCCESS:   success   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ccf_pkg::ST_IDLE;
      received <= '0;
    end else begin
      state    <= state_next;
      received <= received_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_idx   <= hdr_idx_next;
    data_left <= data_left_next;
    idx       <= idx_next;
    cmp_hi    <= cmp_hi_next;
    pay_left  <= pay_left_next;
    verd_r    <= verd_next;
    rd_ok     <= {{(8-RW){1'b0}}, received} > 8'(idx);
    if (acc && (req.command == ccf_pkg::CMD_START)) begin
      count_r     <= ccf_pkg::PKT_OVERHEAD + 8'(dlen_sat);
      opcode_r    <= req.opcode;
      p1_r        <= req.param_one;
      p2_r        <= req.param_two;
      exp_payload <= rlen_sat;
    end
    if (acc && (req.command == ccf_pkg::CMD_DATA)) begin
      byte_r <= req.data_byte;
    end
    if (ram_we && (received == RW'(0))) begin
      cnt_r <= req.data_byte;
    end
    if (ram_we && (received == RW'(1))) begin
      status_r <= req.data_byte;
    end
  end

  // Next state, CRC control and result load
  always_comb begin
    state_next     = state;
    hdr_idx_next   = hdr_idx;
    data_left_next = data_left;
    received_next  = received;
    idx_next       = idx;
    cmp_hi_next    = cmp_hi;
    pay_left_next  = pay_left;
    verd_next      = verd_r;
    crc_ctl        = '{clr: 1'b0, step: 1'b0, din: 8'd0};
    load           = 1'b0;
    load_kind      = ccf_pkg::KIND_TX;
    load_byte      = 8'd0;
    load_verdict   = ccf_pkg::VERD_OK;
    load_status    = 8'd0;
    load_last      = 1'b0;

    // A start is taken in any waiting state and drops the running transaction
    if (acc && (req.command == ccf_pkg::CMD_START)) begin
      state_next     = ccf_pkg::ST_HDR;
      hdr_idx_next   = 3'd0;
      data_left_next = dlen_sat;
      crc_ctl.clr    = 1'b1;
    end else begin
      unique case (state)
        ccf_pkg::ST_IDLE: ;
        ccf_pkg::ST_HDR: begin
          if (slot_free) begin
            load = 1'b1;
            unique case (hdr_idx)
              3'd0:    load_byte = word_addr;
              3'd1:    load_byte = count_r;
              3'd2:    load_byte = opcode_r;
              3'd3:    load_byte = p1_r;
              3'd4:    load_byte = p2_r[7:0];
              default: load_byte = p2_r[15:8];
            endcase
            crc_ctl.step = (hdr_idx != 3'd0);
            crc_ctl.din  = load_byte;
            hdr_idx_next = hdr_idx + 3'd1;
            if (hdr_idx == 3'd5) begin
              state_next = (data_left == '0) ? ccf_pkg::ST_CRC_LO : ccf_pkg::ST_DATA;
            end
          end
        end
        ccf_pkg::ST_DATA: begin
          if (acc && (req.command == ccf_pkg::CMD_DATA)) begin
            state_next = ccf_pkg::ST_TXD;
          end
        end
        ccf_pkg::ST_TXD: begin
          if (slot_free) begin
            load           = 1'b1;
            load_byte      = byte_r;
            crc_ctl.step   = 1'b1;
            crc_ctl.din    = byte_r;
            data_left_next = data_left - 6'd1;
            state_next = (data_left == 6'd1) ? ccf_pkg::ST_CRC_LO : ccf_pkg::ST_DATA;
          end
        end
        ccf_pkg::ST_CRC_LO: begin
          if (slot_free) begin
            load       = 1'b1;
            load_byte  = crc[7:0];
            state_next = ccf_pkg::ST_CRC_HI;
          end
        end
        ccf_pkg::ST_CRC_HI: begin
          if (slot_free) begin
            load          = 1'b1;
            load_byte     = crc[15:8];
            load_last     = 1'b1;
            received_next = '0;
            state_next    = ccf_pkg::ST_REPLY;
          end
        end
        ccf_pkg::ST_REPLY: begin
          if (ram_we) begin
            received_next = received + RW'(1);
            if (8'(received) + 8'd1 >= want) begin
              state_next = ccf_pkg::ST_CHK_START;
            end
          end
        end
        ccf_pkg::ST_CHK_START: begin
          if ((cnt_r < ccf_pkg::SHORT_REPLY) || (cnt_r > PKT_MAX)) begin
            verd_next  = ccf_pkg::VERD_BAD_COUNT;
            state_next = ccf_pkg::ST_VERDICT;
          end else begin
            crc_ctl.clr = 1'b1;
            idx_next    = '0;
            state_next  = ccf_pkg::ST_CHK_RD;
          end
        end
        ccf_pkg::ST_CHK_RD: state_next = ccf_pkg::ST_CHK_ACC;
        ccf_pkg::ST_CHK_ACC: begin
          crc_ctl.step = 1'b1;
          crc_ctl.din  = rd_byte;
          idx_next     = idx + AW'(1);
          state_next   = ccf_pkg::ST_CHK_RD;
          if (8'(idx) + 8'd1 == cnt_r - 8'd2) begin
            cmp_hi_next = 1'b0;
            state_next  = ccf_pkg::ST_CMP_RD;
          end
        end
        ccf_pkg::ST_CMP_RD: state_next = ccf_pkg::ST_CMP_CHK;
        ccf_pkg::ST_CMP_CHK: begin
          if (rd_byte != (cmp_hi ? crc[15:8] : crc[7:0])) begin
            verd_next  = ccf_pkg::VERD_CRC;
            state_next = ccf_pkg::ST_VERDICT;
          end else if (!cmp_hi) begin
            cmp_hi_next = 1'b1;
            idx_next    = idx + AW'(1);
            state_next  = ccf_pkg::ST_CMP_RD;
          end else if ((cnt_r == ccf_pkg::SHORT_REPLY) && (status_r != success)) begin
            verd_next  = ccf_pkg::VERD_DEVICE;
            state_next = ccf_pkg::ST_VERDICT;
          end else if (payload_len != 8'(exp_payload)) begin
            verd_next  = ccf_pkg::VERD_LENGTH;
            state_next = ccf_pkg::ST_VERDICT;
          end else begin
            verd_next     = ccf_pkg::VERD_OK;
            idx_next      = AW'(1);
            pay_left_next = exp_payload;
            state_next = (exp_payload == '0) ? ccf_pkg::ST_VERDICT : ccf_pkg::ST_PAY_RD;
          end
        end
        ccf_pkg::ST_PAY_RD: state_next = ccf_pkg::ST_PAY_OUT;
        ccf_pkg::ST_PAY_OUT: begin
          if (slot_free) begin
            load          = 1'b1;
            load_kind     = ccf_pkg::KIND_PAYLOAD;
            load_byte     = rd_byte;
            idx_next      = idx + AW'(1);
            pay_left_next = pay_left - 6'd1;
            state_next = (pay_left == 6'd1) ? ccf_pkg::ST_VERDICT : ccf_pkg::ST_PAY_RD;
          end
        end
        ccf_pkg::ST_VERDICT: begin
          if (slot_free) begin
            load         = 1'b1;
            load_kind    = ccf_pkg::KIND_VERDICT;
            load_verdict = verd_r;
            load_status  = status_r;
            load_last    = 1'b1;
            state_next   = ccf_pkg::ST_IDLE;
          end
        end
        default: state_next = ccf_pkg::ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind          <= load_kind;
      res.out_byte      <= load_byte;
      res.verdict       <= load_verdict;
      res.device_status <= load_status;
      res.last          <= load_last;
    end
  end

endmodule

>>> design/ccf_checker.sv
`include "crypto_chip_command_framer_assert.svh"

// Port-level checks on the framer result channel
module ccf_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [7:0] res_out_byte,
  input logic [2:0] res_verdict,
  input logic [7:0] res_device_status,
  input logic       res_last
);

  // Result slot is empty right after reset
  `CCF_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !res_valid)

  // A stalled result stays put
  `CCF_ASSERT(a_hold_on_stall, clk, rst,
    res_valid && !res_ready |=> res_valid && $stable(res_out_byte) && $stable(res_kind))

  // Byte results carry no verdict or status
  `CCF_ASSERT(a_byte_fields_clear, clk, rst,
    res_valid && (res_kind != ccf_pkg::KIND_VERDICT) |->
      (res_verdict == ccf_pkg::VERD_OK) && (res_device_status == 8'd0))

  // A verdict closes the reply and has no byte
  `CCF_ASSERT(a_verdict_shape, clk, rst,
    res_valid && (res_kind == ccf_pkg::KIND_VERDICT) |-> res_last && (res_out_byte == 8'd0))

endmodule

bind crypto_chip_command_framer ccf_checker u_ccf_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_kind          (res.kind),
  .res_out_byte      (res.out_byte),
  .res_verdict       (res.verdict),
  .res_device_status (res.device_status),
  .res_last          (res.last)
);
